### rtl/qdst_pkg.sv
// ----------------------------------------------------------------------------
// qdst_pkg
// Shared types and constants for the quadrature detent step tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qdst_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_MUL_SPEED,
        ST_MUL_ANGLE,
        ST_ANGLE_ADD,
        ST_DONE
    } state_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_JUMP        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_DIR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS_PER_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_PER_STEP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_SCALE     = 3'd4;
    localparam int unsigned CFG_DATA_W = 17;

    // Register reset values
    localparam logic [14:0] MAX_JUMP_RST        = 15'd100;
    localparam logic [7:0]  COUNTS_PER_STEP_RST = 8'd4;
    localparam logic [16:0] ANGLE_PER_STEP_RST  = 17'd4608;
    localparam logic [16:0] SPEED_SCALE_RST     = 17'd115200;

    // Action codes
    localparam logic ACT_INIT   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Divider: 17-bit dividend magnitude, one quotient bit a cycle
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic signed [31:0] SPEED_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SPEED_MIN = 32'sh8000_0000;

endpackage : qdst_pkg

`default_nettype wire

### rtl/quadrature_detent_step_tracker_core.sv
// ----------------------------------------------------------------------------
// quadrature_detent_step_tracker_core
// Turns periodic 16-bit quadrature counter samples into detent steps, an
// absolute angle, a running count total and a saturated speed estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: action,
//   counter_value, base_angle. A word is taken when in_valid is high and
//   in_stall low. in_stall is low only while the sequencer is idle.
//   Output channel (out_valid / out_stall) carries one result word per input
//   word; the result sits in an output register until taken, so the next
//   input word can be accepted while it waits.
//   Init, zero-change and glitch words go from classification straight to
//   the done state; a moving sample passes through the shift-subtract
//   divider, then two passes through the shared multiplier and the angle
//   add, and the divider is skipped when counts_per_step is zero.
//   One word in flight at a time, so the next word is not taken until the
//   current result has moved into the output register.
//   If the output register is still full when a result is ready, the
//   sequencer holds in its final state until out_stall drops.
//   Configuration writes (cfg_valid / cfg_ready, always ready) land at once.
//   Reset loads the register defaults and clears all tracking state.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_detent_step_tracker_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [qdst_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [qdst_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input words
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  action,
    input  wire  [15:0]                          counter_value,
    input  wire  signed [31:0]                   base_angle,
    // result words
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [15:0]                   step_delta,
    output logic signed [31:0]                   absolute_angle,
    output logic signed [31:0]                   speed,
    output logic signed [31:0]                   count_total,
    output logic                                 glitch,
    output logic                                 angle_updated
);

    import qdst_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [14:0] max_jump_reg;
    logic        reverse_reg;
    logic [7:0]  cps_reg;
    logic [16:0] aps_reg;
    logic [16:0] speed_scale_reg;

    // tracking state
    logic [15:0]        last_count_reg;
    logic signed [15:0] rem_reg;
    logic signed [31:0] total_reg;
    logic signed [31:0] angle_reg;

    // captured input word
    logic               action_reg;
    logic [15:0]        sample_reg;
    logic signed [31:0] base_reg;

    // working registers
    logic signed [16:0] sd_reg;
    logic signed [16:0] steps_reg;
    logic signed [31:0] speed_reg;
    logic               glitch_reg;
    logic               neg_reg;
    logic [16:0]        div_q_reg;
    logic [7:0]         div_r_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [35:0] prod_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] out_steps_reg;
    logic signed [31:0] out_angle_reg;
    logic signed [31:0] out_speed_reg;
    logic signed [31:0] out_total_reg;
    logic               out_glitch_reg;
    logic               out_upd_reg;

    // control
    logic               load_out;
    logic               div_last;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;

    // classification
    logic signed [15:0] delta;
    logic [15:0]        delta_mag;
    logic               is_glitch;
    logic signed [16:0] sd_val;
    logic signed [16:0] sum_val;
    logic [16:0]        sum_mag;

    // divider step
    logic [8:0]         div_trial;
    logic               div_ge;
    logic [7:0]         div_r_next;
    logic [16:0]        div_q_next;
    logic signed [16:0] steps_next;
    logic signed [15:0] rem_next;

    logic               prod_ovf;
    logic signed [31:0] speed_sat;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    always_comb
    begin
        delta     = $signed(sample_reg - last_count_reg);
        delta_mag = delta[15] ? 16'(-delta) : delta;
        // a change of -32768 has magnitude 0x8000 and always trips this
        is_glitch = delta_mag > {1'b0, max_jump_reg};
        sd_val    = reverse_reg ? -17'(delta) : 17'(delta);
        sum_val   = 17'(rem_reg) + sd_val;
        sum_mag   = sum_val[16] ? 17'(-sum_val) : 17'(sum_val);

        // restoring divide, one quotient bit per cycle
        div_trial  = {div_r_reg, div_q_reg[16]};
        div_ge     = div_trial >= {1'b0, cps_reg};
        div_r_next = div_ge ? 8'(div_trial - {1'b0, cps_reg}) : div_trial[7:0];
        div_q_next = {div_q_reg[15:0], div_ge};
        // truncating division: quotient and remainder take dividend's sign
        steps_next = neg_reg ? -$signed(div_q_next) : $signed(div_q_next);
        rem_next   = neg_reg ? -$signed({8'd0, div_r_next}) : $signed({8'd0, div_r_next});

        mul_p     = mul_a * mul_b;
        prod_ovf  = (prod_reg[35:31] != 5'b00000) && (prod_reg[35:31] != 5'b11111);
        speed_sat = prod_ovf ? (prod_reg[35] ? SPEED_MIN : SPEED_MAX) : prod_reg[31:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                if (action_reg == ACT_INIT || delta == 16'sd0 || is_glitch)
                    state_next = ST_DONE;
                else if (cps_reg == 8'd0)
                    state_next = ST_MUL_SPEED;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_last)
                    state_next = ST_MUL_SPEED;
            end
            ST_MUL_SPEED: state_next = ST_MUL_ANGLE;
            ST_MUL_ANGLE: state_next = ST_ANGLE_ADD;
            ST_ANGLE_ADD: state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = 1'b1;
        load_out  = 1'b0;
        div_last  = 1'b0;
        mul_a     = 18'(steps_reg);
        mul_b     = $signed({1'b0, aps_reg});
        cfg_ready = 1'b1;
        case (state_reg)
            ST_IDLE:      in_stall = 1'b0;
            ST_DIVIDE:    div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
            ST_MUL_SPEED:
            begin
                mul_a = 18'(sd_reg);
                mul_b = $signed({1'b0, speed_scale_reg});
            end
            ST_DONE:      load_out = !out_valid_reg || !out_stall;
            default:      ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_jump_reg    <= MAX_JUMP_RST;
            reverse_reg     <= 1'b0;
            cps_reg         <= COUNTS_PER_STEP_RST;
            aps_reg         <= ANGLE_PER_STEP_RST;
            speed_scale_reg <= SPEED_SCALE_RST;
            last_count_reg  <= '0;
            rem_reg         <= '0;
            total_reg       <= '0;
            angle_reg       <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_JUMP:        max_jump_reg    <= cfg_data[14:0];
                    CFG_REVERSE_DIR:     reverse_reg     <= cfg_data[0];
                    CFG_COUNTS_PER_STEP: cps_reg         <= cfg_data[7:0];
                    CFG_ANGLE_PER_STEP:  aps_reg         <= cfg_data;
                    CFG_SPEED_SCALE:     speed_scale_reg <= cfg_data;
                    default:             ;
                endcase
            end

            case (state_reg)
                ST_CLASSIFY:
                begin
                    last_count_reg <= sample_reg;
                    div_cnt_reg    <= '0;
                    if (action_reg == ACT_INIT)
                    begin
                        rem_reg   <= '0;
                        total_reg <= '0;
                        angle_reg <= base_reg;
                    end
                    else if (delta != 16'sd0 && is_glitch)
                        rem_reg <= '0;
                    else if (delta != 16'sd0)
                    begin
                        total_reg <= total_reg + 32'(sd_val);
                        if (cps_reg == 8'd0)
                            rem_reg <= '0;
                    end
                end
                ST_DIVIDE:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_last)
                        rem_reg <= rem_next;
                end
                ST_ANGLE_ADD: angle_reg <= angle_reg + prod_reg[31:0];
                default:      ;
            endcase

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg <= action;
            sample_reg <= counter_value;
            base_reg   <= base_angle;
        end

        case (state_reg)
            ST_CLASSIFY:
            begin
                sd_reg     <= sd_val;
                steps_reg  <= '0;
                speed_reg  <= '0;
                glitch_reg <= action_reg == ACT_SAMPLE && delta != 16'sd0 && is_glitch;
                neg_reg    <= sum_val[16];
                div_q_reg  <= sum_mag;
                div_r_reg  <= '0;
            end
            ST_DIVIDE:
            begin
                div_q_reg <= div_q_next;
                div_r_reg <= div_r_next;
                if (div_last)
                    steps_reg <= steps_next;
            end
            ST_MUL_SPEED: prod_reg <= mul_p;
            ST_MUL_ANGLE:
            begin
                speed_reg <= speed_sat;
                prod_reg  <= mul_p;
            end
            default: ;
        endcase

        if (load_out)
        begin
            out_steps_reg  <= steps_reg[15:0];
            out_angle_reg  <= angle_reg;
            out_speed_reg  <= speed_reg;
            out_total_reg  <= total_reg;
            out_glitch_reg <= glitch_reg;
            out_upd_reg    <= steps_reg != 17'sd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_delta     = out_steps_reg;
    assign absolute_angle = out_angle_reg;
    assign speed          = out_speed_reg;
    assign count_total    = out_total_reg;
    assign glitch         = out_glitch_reg;
    assign angle_updated  = out_upd_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_classify: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == ST_CLASSIFY)
        else $error("accepted word did not start classification");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> div_cnt_reg < DIV_CNT_W'(DIV_STEPS))
        else $error("divider ran past its step count");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result load did not raise out_valid");

    a_glitch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && glitch) |-> (step_delta == 16'sd0 && speed == 32'sd0))
        else $error("glitch result carries motion");

    a_updated_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle_updated == (step_delta != 16'sd0)))
        else $error("angle_updated disagrees with step_delta");

endmodule : quadrature_detent_step_tracker_core

`default_nettype wire
